[design/byte_ring_queue_peek_flush_assert.svh]
// Assertion macros used by the byte ring queue controller RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef BYTE_RING_QUEUE_PEEK_FLUSH_ASSERT_SVH
`define BYTE_RING_QUEUE_PEEK_FLUSH_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define BRQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle as its cause.
`define BRQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define BRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/brq_pkg.sv]
package brq_pkg;

  // Default queue depth and fixed field widths
  localparam int BRQ_DEPTH_DEF = 64;
  localparam int BYTE_W        = 8;
  localparam int COUNT_W       = 7;
  localparam int FILL_W        = 6;
  localparam logic [COUNT_W-1:0] CHUNK_MAX = 7'd127;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_PEEK  = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_BADCOUNT = 2'd3
  } status_t;

  typedef struct packed {
    action_t             action;
    logic [BYTE_W-1:0]   data_byte;
    logic [COUNT_W-1:0]  count;
    logic                chunk_end;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic [COUNT_W-1:0]  done_length;
    status_t             status;
    logic                last;
    logic [FILL_W-1:0]   stored_count;
  } out_item_t;

endpackage

[design/brq_mem.sv]
module brq_mem import brq_pkg::*; #(
  parameter int DEPTH = BRQ_DEPTH_DEF,
  parameter int IW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IW-1:0]     waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic              re,
  input  logic [IW-1:0]     raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  // Write one byte
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/brq_outq.sv]
module brq_outq import brq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_word,
  output logic [1:0] occ,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  out_item_t  slot_r [2];
  logic       head_r;
  logic [1:0] occ_r;
  logic [1:0] occ_nxt;
  logic       tail;

  assign out_valid = (occ_r != 2'd0);
  assign out_data  = slot_r[head_r];
  assign pop       = out_valid && out_ready;
  assign occ       = occ_r;
  assign tail      = head_r ^ occ_r[0];

  // Track occupancy
  always_comb begin
    case ({push, pop})
      2'b10:   occ_nxt = occ_r + 2'd1;
      2'b01:   occ_nxt = occ_r - 2'd1;
      default: occ_nxt = occ_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 1'b0;
      occ_r  <= 2'd0;
    end else begin
      head_r <= head_r ^ pop;
      occ_r  <= occ_nxt;
    end
  end

  // Hold result words
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[tail] <= push_word;
    end
  end

endmodule

[design/brq_ctrl.sv]
module brq_ctrl import brq_pkg::*; #(
  parameter int DEPTH = BRQ_DEPTH_DEF,
  parameter int IW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              mem_we,
  output logic [IW-1:0]     mem_waddr,
  output logic [BYTE_W-1:0] mem_wdata,
  output logic              mem_re,
  output logic [IW-1:0]     mem_raddr,
  input  logic [BYTE_W-1:0] mem_rdata,
  output logic              q_push,
  output out_item_t         q_data,
  input  logic [1:0]        q_occ,
  input  logic              q_pop
);

  localparam int              IWP      = IW + 1;
  localparam logic [7:0]      DEPTH_W  = 8'(DEPTH);
  localparam logic [IWP-1:0]  DEPTH_I  = IWP'(DEPTH);
  localparam logic [IW-1:0]   LAST_IDX = IW'(DEPTH - 1);

  typedef enum logic {S_IDLE, S_PEEK} state_t;

  state_t              state_r, state_nxt;
  logic [IW-1:0]       wr_idx_r, wr_idx_nxt;
  logic [IW-1:0]       rd_idx_r, rd_idx_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic                chunk_open_r, chunk_open_nxt;
  logic                chunk_acc_r, chunk_acc_nxt;
  logic [COUNT_W-1:0]  chunk_bytes_r, chunk_bytes_nxt;
  logic [IW-1:0]       pk_idx_r, pk_idx_nxt;
  logic [FILL_W-1:0]   pk_left_r, pk_left_nxt;
  logic [FILL_W-1:0]   pk_len_r, pk_len_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic                rd_last_r, rd_last_nxt;

  logic                accept;
  logic [7:0]          fill8, count8;
  logic                is_first, chunk_acc, do_store;
  logic [COUNT_W-1:0]  bytes_base, bytes_after;
  logic [FILL_W-1:0]   take_n;
  logic [IWP-1:0]      rd_sum, rd_wrap;
  logic [2:0]          q_used;
  logic                issue;
  logic [IWP-1:0]      chk_sum, chk_wrap;

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  assign in_ready = (state_r == S_IDLE) && !rd_pend_r && (q_occ != 2'd2);
  assign accept   = in_valid && in_ready;

  // Chunk admission and byte store decision
  assign fill8       = {2'b00, fill_r};
  assign count8      = {1'b0, in_data.count};
  assign is_first    = !chunk_open_r;
  assign chunk_acc   = is_first ? ((in_data.count != '0) && (fill8 + count8 < DEPTH_W))
                                : chunk_acc_r;
  assign do_store    = chunk_acc && (fill8 + 8'd1 < DEPTH_W);
  assign bytes_base  = is_first ? '0 : chunk_bytes_r;
  assign bytes_after = (do_store && bytes_base != CHUNK_MAX) ? bytes_base + 1'b1
                                                             : bytes_base;

  // Bytes taken by a peek or flush, and the advanced head for a flush
  assign take_n  = (count8 < fill8) ? in_data.count[FILL_W-1:0] : fill_r;
  assign rd_sum  = {1'b0, rd_idx_r} + IWP'(take_n);
  assign rd_wrap = (rd_sum >= DEPTH_I) ? rd_sum - DEPTH_I : rd_sum;

  // Issue a peek read only when the result queue will have room for it
  assign q_used = {1'b0, q_occ} + {2'b00, rd_pend_r};
  assign issue  = (q_used <= 3'd1) || (q_pop && q_used <= 3'd2);

  always_comb begin
    state_nxt       = state_r;
    wr_idx_nxt      = wr_idx_r;
    rd_idx_nxt      = rd_idx_r;
    fill_nxt        = fill_r;
    chunk_open_nxt  = chunk_open_r;
    chunk_acc_nxt   = chunk_acc_r;
    chunk_bytes_nxt = chunk_bytes_r;
    pk_idx_nxt      = pk_idx_r;
    pk_left_nxt     = pk_left_r;
    pk_len_nxt      = pk_len_r;
    rd_pend_nxt     = 1'b0;
    rd_last_nxt     = rd_last_r;
    mem_we          = 1'b0;
    mem_waddr       = wr_idx_r;
    mem_wdata       = in_data.data_byte;
    mem_re          = 1'b0;
    mem_raddr       = pk_idx_r;
    q_push          = 1'b0;
    q_data          = '0;

    // Forward a returning peek byte into the result queue
    if (rd_pend_r) begin
      q_push             = 1'b1;
      q_data.out_byte    = mem_rdata;
      q_data.done_length = {1'b0, pk_len_r};
      q_data.status      = ST_OK;
      q_data.last        = rd_last_r;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data.action)
            ACT_PUSH: begin
              if (do_store) begin
                mem_we     = 1'b1;
                wr_idx_nxt = next_slot(wr_idx_r);
                fill_nxt   = fill_r + 1'b1;
              end
              if (in_data.chunk_end) begin
                q_push             = 1'b1;
                q_data.done_length = chunk_acc ? bytes_after : '0;
                q_data.status      = chunk_acc ? ST_OK :
                                     (in_data.count == '0) ? ST_BADCOUNT : ST_OVERFLOW;
                q_data.last        = 1'b1;
                chunk_open_nxt     = 1'b0;
                chunk_acc_nxt      = 1'b0;
                chunk_bytes_nxt    = '0;
              end else begin
                chunk_open_nxt  = 1'b1;
                chunk_acc_nxt   = chunk_acc;
                chunk_bytes_nxt = bytes_after;
              end
            end
            ACT_PEEK: begin
              if (in_data.count == '0) begin
                q_push        = 1'b1;
                q_data.status = ST_BADCOUNT;
                q_data.last   = 1'b1;
              end else if (fill_r == '0) begin
                q_push        = 1'b1;
                q_data.status = ST_EMPTY;
                q_data.last   = 1'b1;
              end else begin
                state_nxt   = S_PEEK;
                pk_idx_nxt  = rd_idx_r;
                pk_left_nxt = take_n;
                pk_len_nxt  = take_n;
              end
            end
            ACT_FLUSH: begin
              q_push      = 1'b1;
              q_data.last = 1'b1;
              if (in_data.count == '0) begin
                q_data.status = ST_BADCOUNT;
              end else if (fill_r == '0) begin
                q_data.status = ST_EMPTY;
              end else begin
                rd_idx_nxt         = rd_wrap[IW-1:0];
                fill_nxt           = fill_r - take_n;
                q_data.done_length = {1'b0, take_n};
                q_data.status      = ST_OK;
              end
            end
            ACT_CLEAR: begin
              wr_idx_nxt    = '0;
              rd_idx_nxt    = '0;
              fill_nxt      = '0;
              q_push        = 1'b1;
              q_data.status = ST_OK;
              q_data.last   = 1'b1;
            end
          endcase
        end
      end
      S_PEEK: begin
        // Stream stored bytes oldest first, one read a cycle while the result queue has room
        if (issue) begin
          mem_re      = 1'b1;
          rd_pend_nxt = 1'b1;
          rd_last_nxt = (pk_left_r == FILL_W'(1));
          pk_idx_nxt  = next_slot(pk_idx_r);
          pk_left_nxt = pk_left_r - 1'b1;
          if (pk_left_r == FILL_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
    endcase

    q_data.stored_count = fill_nxt;
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      wr_idx_r      <= '0;
      rd_idx_r      <= '0;
      fill_r        <= '0;
      chunk_open_r  <= 1'b0;
      chunk_acc_r   <= 1'b0;
      chunk_bytes_r <= '0;
      pk_idx_r      <= '0;
      pk_left_r     <= '0;
      pk_len_r      <= '0;
      rd_pend_r     <= 1'b0;
      rd_last_r     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      wr_idx_r      <= wr_idx_nxt;
      rd_idx_r      <= rd_idx_nxt;
      fill_r        <= fill_nxt;
      chunk_open_r  <= chunk_open_nxt;
      chunk_acc_r   <= chunk_acc_nxt;
      chunk_bytes_r <= chunk_bytes_nxt;
      pk_idx_r      <= pk_idx_nxt;
      pk_left_r     <= pk_left_nxt;
      pk_len_r      <= pk_len_nxt;
      rd_pend_r     <= rd_pend_nxt;
      rd_last_r     <= rd_last_nxt;
    end
  end

  // Tail must sit fill bytes past the head
  assign chk_sum  = {1'b0, rd_idx_r} + IWP'(fill_r);
  assign chk_wrap = (chk_sum >= DEPTH_I) ? chk_sum - DEPTH_I : chk_sum;

`include "byte_ring_queue_peek_flush_assert.svh"

  `BRQ_ASSERT_ALWAYS(a_fill_bound, fill8 < DEPTH_W, "fill count reached depth")
  `BRQ_ASSERT_ALWAYS(a_index_match, wr_idx_r == chk_wrap[IW-1:0], "tail and head disagree")
  `BRQ_ASSERT_IMPL(a_queue_room, q_push && q_occ == 2'd2, q_pop, "result queue overrun")
  `BRQ_ASSERT_IMPL(a_peek_left, state_r == S_PEEK, pk_left_r != '0, "peek with nothing left")
  `BRQ_ASSERT_NEXT(a_read_return, mem_re, rd_pend_r && q_push, "peek byte not queued")

endmodule

[design/byte_ring_queue_peek_flush.sv]
// Push, flush, clear and peek status words each give one result, sent to the result queue.
// A push byte without chunk end gives no result; input takes one word per cycle while
// no peek runs and the result queue has room. Peek of n bytes: registered memory reads,
// one per cycle while the queue has room. Input holds during a peek; queue is 2 words deep.
// Synchronous active-low reset clears indices, fill count, chunk state and result queue;
// the byte store keeps its contents and needs no clearing pass.
module byte_ring_queue_peek_flush import brq_pkg::*; #(
  parameter int DEPTH = BRQ_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int IW = $clog2(DEPTH);

  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [IW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;
  logic              q_push;
  out_item_t         q_data;
  logic [1:0]        q_occ;
  logic              q_pop;

  // Queue control: indices, chunk admission, peek sequencer
  brq_ctrl #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .q_push    (q_push),
    .q_data    (q_data),
    .q_occ     (q_occ),
    .q_pop     (q_pop)
  );

  // Byte store
  brq_mem #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Result queue
  brq_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (q_data),
    .occ       (q_occ),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
